FILE: hdl/motor_backlash_gap_compensator_defines.svh
// Assertion macros for the backlash gap compensator.
// Included by files that check their own logic; needs a clock named i_clk and reset i_rst_n.
`ifndef MOTOR_BACKLASH_GAP_COMPENSATOR_DEFINES_SVH
`define MOTOR_BACKLASH_GAP_COMPENSATOR_DEFINES_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset
`define MBGC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Condition that must never be seen outside reset
`define MBGC_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);
`else
`define MBGC_ASSERT(lbl, prop, msg)
`define MBGC_NEVER(lbl, cond, msg)
`endif
`endif

FILE: hdl/mbgc_pkg.sv
// Shared constants and types for the backlash gap compensator.
// No dependencies; used by the RTL.
package mbgc_pkg;

    // Sample buffer geometry
    localparam int SAMPLE_COUNT = 16;
    localparam int IDX_W        = $clog2(SAMPLE_COUNT);
    localparam int CNT_W        = $clog2(SAMPLE_COUNT + 1);
    localparam int DATA_W       = 16;

    localparam logic [DATA_W-1:0] SAMPLE_MAX = 16'hFFFF;

    // Calibration mode codes
    localparam logic [1:0] FUNC_NORMAL    = 2'd0;
    localparam logic [1:0] FUNC_MEAS_DOWN = 2'd1;
    localparam logic [1:0] FUNC_MEAS_UP   = 2'd2;

    // Motor direction codes
    localparam logic DIR_UP   = 1'b0;
    localparam logic DIR_DOWN = 1'b1;

    typedef logic [IDX_W-1:0] t_idx;

    // Requests from the sequencer to the sample buffer
    typedef struct packed {
        logic              start;
        logic              wr_en;
        t_idx              wr_addr;
        logic [DATA_W-1:0] wr_data;
    } t_scan_cmd;

    // Status back from the sample buffer
    typedef struct packed {
        logic done;
        t_idx min_idx;
    } t_scan_sts;

endpackage

FILE: hdl/motor_backlash_gap_compensator.sv
// Top level of the motor backlash gap compensator.
// Depends on mbgc_pkg, mbgc_min_scan and motor_backlash_gap_compensator_defines.svh.
`include "motor_backlash_gap_compensator_defines.svh"

// One beat in gives one beat out. A normal pulse, or a calibration pulse that
// only stores a sample, goes from ST_IDLE to ST_FINISH and back. A down
// calibration pulse that arrives with the sample buffer full, or an up one
// that does so while the up gap is still zero, triggers the minimum search,
// which reads the sample memory one entry per cycle through a single
// comparator. The input side is not ready while a pulse is in work, but it is
// ready again while the previous result still waits in the output register.
// The sample memory needs no clearing after reset: only entries written since
// the last measurement are ever searched.
module motor_backlash_gap_compensator (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_direction,
    input  logic [1:0]                   i_func,
    input  logic [mbgc_pkg::DATA_W-1:0]  i_window_pos,
    input  logic [mbgc_pkg::DATA_W-1:0]  i_tick_interval,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [mbgc_pkg::DATA_W-1:0]  o_corrected_pos
);
    import mbgc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_FINISH = 3'b100
    } t_state;

    t_state            r_state;
    logic [CNT_W-1:0]  r_fill;
    t_idx              r_down_gap;
    t_idx              r_up_gap;
    logic              r_last_dir;
    logic              r_dir;
    logic [DATA_W-1:0] r_pos;
    logic              r_meas_up;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_pos;

    t_scan_cmd         n_cmd;
    t_scan_sts         sts;
    logic              n_accept;
    logic              n_meas;
    logic              n_full;
    logic              n_scan_go;
    logic              n_emit;
    logic [DATA_W-1:0] n_pos;

    assign o_in_ready = (r_state == ST_IDLE);
    assign n_accept   = i_in_valid && o_in_ready;

    // Decode the incoming beat
    always_comb begin
        n_meas    = (i_func == FUNC_MEAS_DOWN) || (i_func == FUNC_MEAS_UP);
        n_full    = (r_fill == CNT_W'(SAMPLE_COUNT));
        n_scan_go = n_full && ((i_func == FUNC_MEAS_DOWN) ||
                               ((i_func == FUNC_MEAS_UP) && (r_up_gap == '0)));
        n_cmd.start   = n_accept && n_scan_go;
        n_cmd.wr_en   = n_accept && n_meas && !n_full;
        n_cmd.wr_addr = r_fill[IDX_W-1:0];
        n_cmd.wr_data = i_tick_interval;
    end

    mbgc_min_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (n_cmd),
        .o_sts   (sts)
    );

    // Gap compensation on a direction change
    always_comb begin
        n_pos = r_pos;
        if (r_dir != r_last_dir) begin
            if (!r_dir) begin
                n_pos = r_pos + DATA_W'(r_up_gap);
            end else begin
                n_pos = r_pos - DATA_W'(r_down_gap);
            end
        end
        n_emit = (r_state == ST_FINISH) && (!r_out_valid || i_out_ready);
    end

    // Sequencer and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_down_gap  <= '0;
            r_up_gap    <= '0;
            r_last_dir  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (n_accept) begin
                        if (n_cmd.wr_en) begin
                            r_fill <= r_fill + CNT_W'(1);
                        end
                        r_state <= n_scan_go ? ST_SCAN : ST_FINISH;
                    end
                end
                ST_SCAN: begin
                    if (sts.done) begin
                        if (r_meas_up) begin
                            r_up_gap <= sts.min_idx;
                        end else begin
                            r_down_gap <= sts.min_idx;
                        end
                        r_fill  <= '0;
                        r_state <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (n_emit) begin
                        r_last_dir <= r_dir;
                        r_state    <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase

            // Output register
            if (n_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Beat payload and result registers
    always_ff @(posedge i_clk) begin
        if (n_accept) begin
            r_dir     <= i_direction;
            r_pos     <= i_window_pos;
            r_meas_up <= (i_func == FUNC_MEAS_UP);
        end
        if (n_emit) begin
            r_out_pos <= n_pos;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_corrected_pos = r_out_pos;

    // Checks
    `MBGC_NEVER(a_fill_range, r_fill > CNT_W'(SAMPLE_COUNT), "fill count past buffer size")
    `MBGC_ASSERT(a_done_in_scan, sts.done |-> r_state == ST_SCAN, "scan done outside scan state")
    `MBGC_ASSERT(a_clear_after_scan, sts.done |=> r_fill == '0, "fill count not cleared")
    `MBGC_ASSERT(a_state_onehot, $onehot(r_state), "state register not one-hot")

endmodule

FILE: hdl/mbgc_min_scan.sv
// Sample memory plus a one-compare-per-cycle search for the first minimum.
// Depends on mbgc_pkg.
module mbgc_min_scan (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mbgc_pkg::t_scan_cmd i_cmd,
    output mbgc_pkg::t_scan_sts o_sts
);
    import mbgc_pkg::*;

    logic [DATA_W-1:0] r_mem [SAMPLE_COUNT];

    logic              r_active;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_rd_vld;
    t_idx              r_rd_idx;
    logic [DATA_W-1:0] r_rd_data;
    logic [DATA_W-1:0] r_best;
    t_idx              r_at;

    logic              n_issue;
    logic              n_lower;
    logic [DATA_W-1:0] n_best;
    t_idx              n_at;
    logic              n_done;

    assign n_issue = r_active && (r_cnt < CNT_W'(SAMPLE_COUNT));

    // Memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_cmd.wr_addr] <= i_cmd.wr_data;
        end
        if (n_issue) begin
            r_rd_data <= r_mem[r_cnt[IDX_W-1:0]];
        end
    end

    // Shared comparator: strictly lower keeps the first minimum
    always_comb begin
        n_lower = r_rd_vld && (r_rd_data < r_best);
        n_best  = n_lower ? r_rd_data : r_best;
        n_at    = n_lower ? r_rd_idx  : r_at;
        n_done  = r_active && r_rd_vld && (r_rd_idx == IDX_W'(SAMPLE_COUNT - 1));
    end

    // Scan sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_cnt    <= '0;
            r_rd_vld <= 1'b0;
            r_rd_idx <= '0;
            r_best   <= SAMPLE_MAX;
            r_at     <= '0;
        end else if (i_cmd.start) begin
            r_active <= 1'b1;
            r_cnt    <= '0;
            r_rd_vld <= 1'b0;
            r_best   <= SAMPLE_MAX;
            r_at     <= '0;
        end else if (r_active) begin
            if (n_issue) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
            r_rd_vld <= n_issue;
            r_rd_idx <= r_cnt[IDX_W-1:0];
            r_best   <= n_best;
            r_at     <= n_at;
            if (n_done) begin
                r_active <= 1'b0;
            end
        end
    end

    assign o_sts.done    = n_done;
    assign o_sts.min_idx = n_at;

endmodule
